// ===== src/bpw_pkg.sv =====
`timescale 1ns / 1ps

package bpw_pkg;

    localparam int MAX_ATOMS = 32;
    localparam int IDX_W     = $clog2(MAX_ATOMS);
    localparam int CNT_W     = $clog2(MAX_ATOMS + 1);
    localparam int PAIR_W    = $clog2(MAX_ATOMS * MAX_ATOMS);
    localparam int SUM_W     = 31 + IDX_W;
    localparam int DEN_W     = (SUM_W > 32) ? SUM_W : 32;
    localparam int NUM_W     = 96;
    localparam int DIV_STEPS = NUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int INV_SHIFT = 44;

    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
    localparam logic [31:0] SAT32   = 32'hFFFF_FFFF;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_POINT = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RD, ST_SQX, ST_SQY, ST_SQZ, ST_SQA, ST_SQS, ST_SQW,
        ST_DVS, ST_DVW, ST_PW1, ST_PW2, ST_PDW, ST_RJ0, ST_RJ1, ST_K0,
        ST_K1, ST_K2, ST_P1, ST_P2, ST_P3, ST_S, ST_M2, ST_RE, ST_FIN,
        ST_FW1, ST_FW2, ST_FW3, ST_FDS, ST_FDW
    } t_state;

    typedef struct packed {
        logic        start;
        logic [63:0] value;
    } t_sqrt_req;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } t_sqrt_rsp;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } t_div_rsp;

    function automatic logic [63:0] add_sat64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

endpackage

// ===== src/bpw_mul.sv =====
`timescale 1ns / 1ps

// Shared 32 x 32 unsigned multiplier with a registered product.
module bpw_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== src/bpw_sqrt.sv =====
`timescale 1ns / 1ps

// Floor square root of a 64-bit value, one result bit per cycle.
module bpw_sqrt (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bpw_pkg::t_sqrt_req     i_req,
    output bpw_pkg::t_sqrt_rsp     o_rsp
);

    logic [63:0] r_v;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic        r_run;
    logic        r_done;
    logic [63:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_v   <= i_req.value;
                r_res <= 64'd0;
                r_bit <= 64'd1 << 62;
                r_run <= 1'b1;
            end else if (r_run) begin
                if (r_v >= trial) begin
                    r_v   <= r_v - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
                if (r_bit[0]) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_res[31:0];

endmodule

// ===== src/bpw_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle; keeps the low 64 quotient bits.
module bpw_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bpw_pkg::t_div_req i_req,
    output bpw_pkg::t_div_rsp o_rsp
);

    logic [bpw_pkg::NUM_W-1:0]     r_num;
    logic [bpw_pkg::DEN_W-1:0]     r_den;
    logic [bpw_pkg::DEN_W-1:0]     r_rem;
    logic [63:0]                   r_q;
    logic [bpw_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_run;
    logic                          r_done;
    logic [bpw_pkg::DEN_W:0]       rem_sh;
    logic [bpw_pkg::DEN_W:0]       rem_sub;
    logic                          ge;

    assign rem_sh  = {r_rem, r_num[bpw_pkg::NUM_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_num <= i_req.num;
                r_den <= i_req.den;
                r_rem <= '0;
                r_q   <= 64'd0;
                r_cnt <= bpw_pkg::DIV_CNT_W'(bpw_pkg::DIV_STEPS - 1);
                r_run <= 1'b1;
            end else if (r_run) begin
                r_rem <= ge ? rem_sub[bpw_pkg::DEN_W-1:0] : rem_sh[bpw_pkg::DEN_W-1:0];
                r_num <= r_num << 1;
                r_q   <= {r_q[62:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

// ===== src/becke_partition_weight_core.sv =====
`timescale 1ns / 1ps

// Channel       Handshake                  Payload
// input item    start high, busy low       i_kind, i_atom_slot, i_pos_x/y/z,
//                                          i_raw_weight, i_owner_atom
// result        o_done high for one cycle  o_final_weight, o_zero_sum
// config write  i_cfg_we high              i_cfg_wdata (atom count)
//
// An atom load forms an inverse pair distance for every lower slot, through the
// 32-step square root and the 96-step divider. A point forms its distances, then
// the cell factors through the shared multiplier, and ends with the final division
// unless the sum is zero or the owner is out of range.
// Reset is synchronous and active low; it sets the atom count to one.
// Results cannot be stalled: o_done is a single-cycle strobe.
module becke_partition_weight_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_kind,
    input  logic [4:0]  i_atom_slot,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [63:0] i_raw_weight,
    input  logic [4:0]  i_owner_atom,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,
    output logic        o_done,
    output logic [63:0] o_final_weight,
    output logic        o_zero_sum
);

    localparam int M = bpw_pkg::MAX_ATOMS;

    bpw_pkg::t_state r_state, n_state;

    // Atom positions, pair inverse distances and distances of the current point.
    logic [31:0] mem_x  [M];
    logic [31:0] mem_y  [M];
    logic [31:0] mem_z  [M];
    logic [31:0] mem_inv[M*M];
    logic [31:0] mem_pd [M];

    logic [31:0] r_cx, r_cy, r_cz, r_inv_q, r_pd_q;

    logic [5:0]                  r_count;
    logic [bpw_pkg::CNT_W-1:0]   r_n;
    logic [bpw_pkg::CNT_W-1:0]   r_j;
    logic [bpw_pkg::CNT_W-1:0]   r_k;
    logic [bpw_pkg::IDX_W-1:0]   r_slot;
    logic                        r_mode;
    logic [31:0]                 r_px, r_py, r_pz;
    logic [63:0]                 r_w;
    logic [4:0]                  r_owner;
    logic                        r_msat;
    logic [63:0]                 r_acc;
    logic [31:0]                 r_dist;
    logic [31:0]                 r_inv;
    logic [31:0]                 r_dj;
    logic                        r_neg;
    logic [31:0]                 r_a;
    logic [1:0]                  r_rnd;
    logic [31:0]                 r_p;
    logic [bpw_pkg::SUM_W-1:0]   r_sum;
    logic [31:0]                 r_pown;
    logic [63:0]                 r_lo;
    logic [bpw_pkg::NUM_W-1:0]   r_num;
    logic                        r_done;
    logic [63:0]                 r_ow;
    logic                        r_ozs;

    logic                        accept;
    logic                        slot_ok;
    logic [bpw_pkg::CNT_W-1:0]   n_clamped;
    logic [32:0]                 dx, dy, dz, dsel, dmag;
    logic [31:0]                 mul_a, mul_b;
    logic [63:0]                 mul_p;
    logic [63:0]                 term;
    logic [31:0]                 dmag32;
    logic                        dneg;
    logic [49:0]                 mu_t;
    logic [33:0]                 poly3;
    logic [32:0]                 s_full;
    logic                        inv_we;
    logic [bpw_pkg::PAIR_W-1:0]  inv_waddr;
    logic [bpw_pkg::PAIR_W-1:0]  inv_raddr;
    logic [bpw_pkg::IDX_W-1:0]   pd_raddr;
    logic                        j_last;
    logic                        k_end;
    logic                        owner_hit;
    logic                        owner_bad;

    bpw_pkg::t_sqrt_req sqrt_req;
    bpw_pkg::t_sqrt_rsp sqrt_rsp;
    bpw_pkg::t_div_req  div_req;
    bpw_pkg::t_div_rsp  div_rsp;

    bpw_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    bpw_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sqrt_req),
        .o_rsp   (sqrt_rsp)
    );

    bpw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign busy    = (r_state != bpw_pkg::ST_IDLE);
    assign accept  = start && !busy;
    assign slot_ok = int'(i_atom_slot) < M;

    // A count of zero behaves as one, and counts beyond the storage are clipped.
    always_comb begin
        if (r_count == 6'd0) begin
            n_clamped = bpw_pkg::CNT_W'(1);
        end else if (int'(r_count) > M) begin
            n_clamped = bpw_pkg::CNT_W'(M);
        end else begin
            n_clamped = bpw_pkg::CNT_W'(r_count);
        end
    end

    // Coordinate differences; a magnitude of 2^32 or more saturates the square.
    assign dx = {r_px[31], r_px} - {r_cx[31], r_cx};
    assign dy = {r_py[31], r_py} - {r_cy[31], r_cy};
    assign dz = {r_pz[31], r_pz} - {r_cz[31], r_cz};
    always_comb begin
        case (r_state)
            bpw_pkg::ST_SQY: dsel = dy;
            bpw_pkg::ST_SQZ: dsel = dz;
            default:         dsel = dx;
        endcase
    end
    assign dmag = dsel[32] ? (33'd0 - dsel) : dsel;
    assign term = r_msat ? 64'hFFFF_FFFF_FFFF_FFFF : mul_p;

    // mu takes the sign of d_j - d_k and works on the magnitude.
    assign dneg   = r_dj < r_pd_q;
    assign dmag32 = dneg ? (r_pd_q - r_dj) : (r_dj - r_pd_q);
    assign mu_t   = mul_p[63:14];
    assign poly3  = ({2'b00, r_a} << 1) + {2'b00, r_a} - {2'b00, mul_p[61:30]};
    assign s_full = r_neg ? ({1'b0, bpw_pkg::ONE_Q30} + {1'b0, r_a})
                          : ({1'b0, bpw_pkg::ONE_Q30} - {1'b0, r_a});

    assign j_last    = (int'(r_j) + 1) == int'(r_mode ? r_n : bpw_pkg::CNT_W'(r_slot));
    assign k_end     = r_k == r_n;
    assign owner_hit = int'(r_owner) == int'(r_j);
    assign owner_bad = int'(r_owner) >= int'(r_n);

    assign inv_raddr = bpw_pkg::PAIR_W'(int'(r_j) * M + int'(r_k));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bpw_pkg::ST_IDLE: begin
                if (accept) begin
                    if (i_kind == bpw_pkg::KIND_POINT) begin
                        n_state = bpw_pkg::ST_RD;
                    end else if (slot_ok && i_atom_slot != 5'd0) begin
                        n_state = bpw_pkg::ST_RD;
                    end
                end
            end
            bpw_pkg::ST_RD:  n_state = bpw_pkg::ST_SQX;
            bpw_pkg::ST_SQX: n_state = bpw_pkg::ST_SQY;
            bpw_pkg::ST_SQY: n_state = bpw_pkg::ST_SQZ;
            bpw_pkg::ST_SQZ: n_state = bpw_pkg::ST_SQA;
            bpw_pkg::ST_SQA: n_state = bpw_pkg::ST_SQS;
            bpw_pkg::ST_SQS: n_state = bpw_pkg::ST_SQW;
            bpw_pkg::ST_SQW: begin
                if (sqrt_rsp.done) begin
                    n_state = r_mode ? bpw_pkg::ST_PDW : bpw_pkg::ST_DVS;
                end
            end
            bpw_pkg::ST_DVS: n_state = (r_dist == 32'd0) ? bpw_pkg::ST_PW1 : bpw_pkg::ST_DVW;
            bpw_pkg::ST_DVW: if (div_rsp.done) n_state = bpw_pkg::ST_PW1;
            bpw_pkg::ST_PW1: n_state = bpw_pkg::ST_PW2;
            bpw_pkg::ST_PW2: n_state = j_last ? bpw_pkg::ST_IDLE : bpw_pkg::ST_RD;
            bpw_pkg::ST_PDW: n_state = j_last ? bpw_pkg::ST_RJ0 : bpw_pkg::ST_RD;
            bpw_pkg::ST_RJ0: n_state = bpw_pkg::ST_RJ1;
            bpw_pkg::ST_RJ1: n_state = bpw_pkg::ST_K0;
            bpw_pkg::ST_K0: begin
                if (k_end) begin
                    n_state = bpw_pkg::ST_RE;
                end else if (r_k != r_j) begin
                    n_state = bpw_pkg::ST_K1;
                end
            end
            bpw_pkg::ST_K1:  n_state = bpw_pkg::ST_K2;
            bpw_pkg::ST_K2:  n_state = bpw_pkg::ST_P1;
            bpw_pkg::ST_P1:  n_state = bpw_pkg::ST_P2;
            bpw_pkg::ST_P2:  n_state = bpw_pkg::ST_P3;
            bpw_pkg::ST_P3:  n_state = (r_rnd == 2'd2) ? bpw_pkg::ST_S : bpw_pkg::ST_P1;
            bpw_pkg::ST_S:   n_state = bpw_pkg::ST_M2;
            bpw_pkg::ST_M2:  n_state = bpw_pkg::ST_K0;
            bpw_pkg::ST_RE:  n_state = j_last ? bpw_pkg::ST_FIN : bpw_pkg::ST_RJ0;
            bpw_pkg::ST_FIN: begin
                if (r_sum == '0 || owner_bad) begin
                    n_state = bpw_pkg::ST_IDLE;
                end else begin
                    n_state = bpw_pkg::ST_FW1;
                end
            end
            bpw_pkg::ST_FW1: n_state = bpw_pkg::ST_FW2;
            bpw_pkg::ST_FW2: n_state = bpw_pkg::ST_FW3;
            bpw_pkg::ST_FW3: n_state = bpw_pkg::ST_FDS;
            bpw_pkg::ST_FDS: n_state = bpw_pkg::ST_FDW;
            bpw_pkg::ST_FDW: if (div_rsp.done) n_state = bpw_pkg::ST_IDLE;
            default:         n_state = bpw_pkg::ST_IDLE;
        endcase
    end

    // Unit operands, unit starts and memory controls.
    always_comb begin
        mul_a          = 32'd0;
        mul_b          = 32'd0;
        sqrt_req.start = 1'b0;
        sqrt_req.value = r_acc;
        div_req.start  = 1'b0;
        div_req.num    = bpw_pkg::NUM_W'(1) << bpw_pkg::INV_SHIFT;
        div_req.den    = bpw_pkg::DEN_W'(r_dist);
        inv_we         = 1'b0;
        inv_waddr      = bpw_pkg::PAIR_W'(int'(r_slot) * M + int'(r_j));
        pd_raddr       = r_k[bpw_pkg::IDX_W-1:0];
        unique case (r_state)
            bpw_pkg::ST_SQX, bpw_pkg::ST_SQY, bpw_pkg::ST_SQZ: begin
                mul_a = dmag[31:0];
                mul_b = dmag[31:0];
            end
            bpw_pkg::ST_SQS: sqrt_req.start = 1'b1;
            bpw_pkg::ST_DVS: div_req.start = (r_dist != 32'd0);
            bpw_pkg::ST_PW1: inv_we = 1'b1;
            bpw_pkg::ST_PW2: begin
                inv_we    = 1'b1;
                inv_waddr = bpw_pkg::PAIR_W'(int'(r_j) * M + int'(r_slot));
            end
            bpw_pkg::ST_RJ0: pd_raddr = r_j[bpw_pkg::IDX_W-1:0];
            bpw_pkg::ST_K1: begin
                mul_a = dmag32;
                mul_b = r_inv_q;
            end
            bpw_pkg::ST_P1: begin
                mul_a = r_a;
                mul_b = r_a;
            end
            bpw_pkg::ST_P2: begin
                mul_a = r_a;
                mul_b = mul_p[61:30];
            end
            bpw_pkg::ST_S: begin
                mul_a = r_p;
                mul_b = s_full[32:1];
            end
            bpw_pkg::ST_FW1: begin
                mul_a = r_w[31:0];
                mul_b = r_pown;
            end
            bpw_pkg::ST_FW2: begin
                mul_a = r_w[63:32];
                mul_b = r_pown;
            end
            bpw_pkg::ST_FDS: begin
                div_req.start = 1'b1;
                div_req.num   = r_num;
                div_req.den   = bpw_pkg::DEN_W'(r_sum);
            end
            default: begin
            end
        endcase
    end

    // Memories with registered reads.
    always_ff @(posedge i_clk) begin
        if (accept && i_kind == bpw_pkg::KIND_LOAD && slot_ok) begin
            mem_x[bpw_pkg::IDX_W'(i_atom_slot)] <= i_pos_x;
            mem_y[bpw_pkg::IDX_W'(i_atom_slot)] <= i_pos_y;
            mem_z[bpw_pkg::IDX_W'(i_atom_slot)] <= i_pos_z;
        end
        r_cx <= mem_x[r_j[bpw_pkg::IDX_W-1:0]];
        r_cy <= mem_y[r_j[bpw_pkg::IDX_W-1:0]];
        r_cz <= mem_z[r_j[bpw_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (inv_we) begin
            mem_inv[inv_waddr] <= r_inv;
        end
        r_inv_q <= mem_inv[inv_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bpw_pkg::ST_PDW) begin
            mem_pd[r_j[bpw_pkg::IDX_W-1:0]] <= r_dist;
        end
        r_pd_q <= mem_pd[pd_raddr];
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpw_pkg::ST_IDLE;
            r_count <= 6'd1;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            r_done <= ((r_state == bpw_pkg::ST_FIN) && (n_state == bpw_pkg::ST_IDLE)) ||
                      ((r_state == bpw_pkg::ST_FDW) && div_rsp.done);
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            bpw_pkg::ST_IDLE: begin
                if (accept) begin
                    r_px    <= i_pos_x;
                    r_py    <= i_pos_y;
                    r_pz    <= i_pos_z;
                    r_w     <= i_raw_weight;
                    r_owner <= i_owner_atom;
                    r_slot  <= bpw_pkg::IDX_W'(i_atom_slot);
                    r_mode  <= i_kind;
                    r_n     <= n_clamped;
                    r_j     <= '0;
                    r_sum   <= '0;
                    r_pown  <= 32'd0;
                end
            end
            bpw_pkg::ST_SQX: r_msat <= dmag[32];
            bpw_pkg::ST_SQY: begin
                r_msat <= dmag[32];
                r_acc  <= term;
            end
            bpw_pkg::ST_SQZ: begin
                r_msat <= dmag[32];
                r_acc  <= bpw_pkg::add_sat64(r_acc, term);
            end
            bpw_pkg::ST_SQA: r_acc <= bpw_pkg::add_sat64(r_acc, term);
            bpw_pkg::ST_SQW: if (sqrt_rsp.done) r_dist <= sqrt_rsp.root;
            bpw_pkg::ST_DVS: r_inv <= bpw_pkg::SAT32;
            bpw_pkg::ST_DVW: begin
                if (div_rsp.done) begin
                    r_inv <= (div_rsp.quot[63:32] != 32'd0) ? bpw_pkg::SAT32
                                                           : div_rsp.quot[31:0];
                end
            end
            bpw_pkg::ST_PW2: r_j <= j_last ? '0 : r_j + 1'b1;
            bpw_pkg::ST_PDW: r_j <= j_last ? '0 : r_j + 1'b1;
            bpw_pkg::ST_RJ1: begin
                r_dj <= r_pd_q;
                r_p  <= bpw_pkg::ONE_Q30;
                r_k  <= '0;
            end
            bpw_pkg::ST_K0: if (!k_end && r_k == r_j) r_k <= r_k + 1'b1;
            bpw_pkg::ST_K1: r_neg <= dneg;
            bpw_pkg::ST_K2: begin
                r_a   <= (mu_t > 50'(bpw_pkg::ONE_Q30)) ? bpw_pkg::ONE_Q30 : mu_t[31:0];
                r_rnd <= 2'd0;
            end
            bpw_pkg::ST_P3: begin
                r_a   <= poly3[32:1];
                r_rnd <= r_rnd + 2'd1;
            end
            bpw_pkg::ST_M2: begin
                r_p <= mul_p[61:30];
                r_k <= r_k + 1'b1;
            end
            bpw_pkg::ST_RE: begin
                r_sum <= r_sum + bpw_pkg::SUM_W'(r_p);
                if (owner_hit) begin
                    r_pown <= r_p;
                end
                r_j <= r_j + 1'b1;
            end
            bpw_pkg::ST_FIN: begin
                r_ow  <= 64'd0;
                r_ozs <= (r_sum == '0);
            end
            bpw_pkg::ST_FW2: r_lo <= mul_p;
            bpw_pkg::ST_FW3: r_num <= {mul_p, 32'd0} + {32'd0, r_lo};
            bpw_pkg::ST_FDW: if (div_rsp.done) r_ow <= div_rsp.quot;
            default: begin
            end
        endcase
    end

    assign o_done         = r_done;
    assign o_final_weight = r_ow;
    assign o_zero_sum     = r_ozs;

endmodule

// ===== src/bpw_checker.sv =====
`timescale 1ns / 1ps

module bpw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_kind,
    input logic        o_done,
    input logic [63:0] o_final_weight,
    input logic        o_zero_sum
);

    // A zero sum of cell products always yields a zero weight.
    a_zero_sum_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_zero_sum |-> o_final_weight == 64'd0)
        else $error("zero_sum reported with a nonzero weight");

    // A point transaction always keeps the block busy in the next cycle.
    a_point_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_kind |=> busy)
        else $error("point transaction did not make the block busy");

    // A result only follows work that kept the block busy.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without preceding work");

    // Each result strobe lasts exactly one cycle.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

endmodule

bind becke_partition_weight_core bpw_checker u_bpw_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_kind         (i_kind),
    .o_done         (o_done),
    .o_final_weight (o_final_weight),
    .o_zero_sum     (o_zero_sum)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    // A stall limit well above the slowest single transactions: a point with all
    // 32 atoms and a load of the top slot.
    localparam int STALL_LIMIT = 200000;

    typedef struct {
        logic        kind;
        logic [4:0]  slot;
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic [63:0] raw;
        logic [4:0]  owner;
    } t_item;

    typedef struct {
        logic [63:0] weight;
        logic        zero;
    } t_weight_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_kind;
    logic [4:0]  i_atom_slot;
    logic [31:0] i_pos_x;
    logic [31:0] i_pos_y;
    logic [31:0] i_pos_z;
    logic [63:0] i_raw_weight;
    logic [4:0]  i_owner_atom;
    logic        i_cfg_we;
    logic [5:0]  i_cfg_wdata;
    logic        o_done;
    logic [63:0] o_final_weight;
    logic        o_zero_sum;

    becke_partition_weight_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_atom_slot   (i_atom_slot),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_pos_z       (i_pos_z),
        .i_raw_weight  (i_raw_weight),
        .i_owner_atom  (i_owner_atom),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_done        (o_done),
        .o_final_weight(o_final_weight),
        .o_zero_sum    (o_zero_sum)
    );

    // Pending transactions, expected weights and the shadow copy of the block state.
    t_item       pending_items[$];
    t_weight_res weight_expect[$];
    logic signed [31:0] atom_pos[bpw_pkg::MAX_ATOMS*3];
    logic [31:0] inv_pair[bpw_pkg::MAX_ATOMS*bpw_pkg::MAX_ATOMS];
    logic [5:0]  count_reg;
    int          idle_pct;
    int          fail_cnt;
    int          stall_cyc;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Predictor arithmetic. Distances are floor square roots of the saturated
    // sum of squared Q16.16 differences.
    // ---------------------------------------------------------------------
    function automatic logic [63:0] axis_square(logic signed [31:0] a, logic signed [31:0] b);
        longint      diff;
        logic [63:0] mag;
        diff = longint'(a) - longint'(b);
        mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
        if (mag > 64'hFFFF_FFFF) return '1;
        return mag * mag;
    endfunction

    function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

    function automatic logic [31:0] floor_root(logic [63:0] v);
        logic [31:0] root;
        logic [31:0] trial;
        root = '0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (32'd1 << b);
            if (64'(trial) * 64'(trial) <= v) root = trial;
        end
        return root;
    endfunction

    function automatic logic [31:0] span(logic signed [31:0] ax, logic signed [31:0] ay,
                                         logic signed [31:0] az, logic signed [31:0] bx,
                                         logic signed [31:0] by, logic signed [31:0] bz);
        logic [63:0] acc;
        acc = axis_square(ax, bx);
        acc = sat_sum(acc, axis_square(ay, by));
        acc = sat_sum(acc, axis_square(az, bz));
        return floor_root(acc);
    endfunction

    function automatic logic [31:0] recip_q28(logic [31:0] d);
        logic [63:0] q;
        if (d == 0) return bpw_pkg::SAT32;
        q = (64'd1 << bpw_pkg::INV_SHIFT) / 64'(d);
        return (q > 64'(bpw_pkg::SAT32)) ? bpw_pkg::SAT32 : q[31:0];
    endfunction

    function automatic logic [63:0] smooth_step(logic [63:0] a);
        logic [63:0] a2;
        logic [63:0] a3;
        a2 = (a * a) >> 30;
        a3 = (a * a2) >> 30;
        return (3 * a - a3) >> 1;
    endfunction

    // Cell factor s_jk: the signed ratio of distance difference to pair distance,
    // clamped at one and passed three times through the smoothing polynomial.
    function automatic logic [63:0] cell_share(logic [31:0] dj, logic [31:0] dk,
                                               logic [31:0] inv);
        logic        neg;
        logic [63:0] mag;
        logic [63:0] a;
        neg = dj < dk;
        mag = neg ? 64'(dk - dj) : 64'(dj - dk);
        a   = (mag * 64'(inv)) >> 14;
        if (a > 64'(bpw_pkg::ONE_Q30)) a = 64'(bpw_pkg::ONE_Q30);
        a = smooth_step(smooth_step(smooth_step(a)));
        return neg ? (64'(bpw_pkg::ONE_Q30) + a) >> 1 : (64'(bpw_pkg::ONE_Q30) - a) >> 1;
    endfunction

    // Applies one accepted transaction to the shadow state; a point yields the
    // expected partitioned weight.
    task automatic apply_item(t_item it);
        logic [31:0]  pt_dist[bpw_pkg::MAX_ATOMS];
        logic [63:0]  prod[bpw_pkg::MAX_ATOMS];
        logic [63:0]  total;
        logic [127:0] wide;
        t_weight_res  r;
        int           n;
        int           s;
        if (it.kind == bpw_pkg::KIND_LOAD) begin
            s = it.slot;
            atom_pos[s*3]   = it.px;
            atom_pos[s*3+1] = it.py;
            atom_pos[s*3+2] = it.pz;
            for (int j = 0; j < s; j++) begin
                inv_pair[s*bpw_pkg::MAX_ATOMS+j] =
                    recip_q28(span(it.px, it.py, it.pz, atom_pos[j*3],
                                   atom_pos[j*3+1], atom_pos[j*3+2]));
                inv_pair[j*bpw_pkg::MAX_ATOMS+s] = inv_pair[s*bpw_pkg::MAX_ATOMS+j];
            end
        end else begin
            n = count_reg;
            if (n == 0) n = 1;
            if (n > bpw_pkg::MAX_ATOMS) n = bpw_pkg::MAX_ATOMS;
            for (int j = 0; j < n; j++)
                pt_dist[j] = span(it.px, it.py, it.pz, atom_pos[j*3], atom_pos[j*3+1],
                                  atom_pos[j*3+2]);
            total = '0;
            for (int j = 0; j < n; j++) begin
                prod[j] = 64'(bpw_pkg::ONE_Q30);
                for (int k = 0; k < n; k++)
                    if (k != j)
                        prod[j] = (prod[j] *
                                   cell_share(pt_dist[j], pt_dist[k],
                                              inv_pair[j*bpw_pkg::MAX_ATOMS+k])) >> 30;
                total += prod[j];
            end
            r.zero = (total == 0);
            if (total == 0 || it.owner >= n) begin
                r.weight = '0;
            end else begin
                wide     = (128'(it.raw) * 128'(prod[it.owner])) / 128'(total);
                r.weight = wide[63:0];
            end
            weight_expect.push_back(r);
        end
    endtask

    // ---------------------------------------------------------------------
    // Driver: presents the next pending transaction, with random gaps.
    // ---------------------------------------------------------------------
    t_item cur_item;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) apply_item(cur_item);
            if (!start || !busy) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    cur_item     = pending_items.pop_front();
                    start        <= 1'b1;
                    i_kind       <= cur_item.kind;
                    i_atom_slot  <= cur_item.slot;
                    i_pos_x      <= cur_item.px;
                    i_pos_y      <= cur_item.py;
                    i_pos_z      <= cur_item.pz;
                    i_raw_weight <= cur_item.raw;
                    i_owner_atom <= cur_item.owner;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobe is matched against the oldest expected weight.
    always @(posedge i_clk) begin
        t_weight_res e;
        if (i_rst_n && o_done) begin
            if (weight_expect.size() == 0) begin
                $display("%0t: unexpected result weight %h zero_sum %b", $time,
                         o_final_weight, o_zero_sum);
                fail_cnt++;
            end else begin
                e = weight_expect.pop_front();
                if (o_final_weight !== e.weight) begin
                    $display("%0t: final_weight expected %h actual %h", $time, e.weight,
                             o_final_weight);
                    fail_cnt++;
                end
                if (o_zero_sum !== e.zero) begin
                    $display("%0t: zero_sum expected %b actual %b", $time, e.zero, o_zero_sum);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || i_cfg_we || !i_rst_n) begin
            stall_cyc <= 0;
        end else if (stall_cyc >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cyc <= stall_cyc + 1;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus sequencing. Items are queued at the falling edge so that the
    // driver never races the queue.
    // ---------------------------------------------------------------------
    task automatic add_load(int slot, logic [31:0] x, logic [31:0] y, logic [31:0] z);
        t_item it;
        it.kind  = bpw_pkg::KIND_LOAD;
        it.slot  = slot[4:0];
        it.px    = x;
        it.py    = y;
        it.pz    = z;
        it.raw   = {$urandom, $urandom};
        it.owner = $urandom_range(31);
        pending_items.push_back(it);
    endtask

    task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                             logic [63:0] raw, int owner);
        t_item it;
        it.kind  = bpw_pkg::KIND_POINT;
        it.slot  = $urandom_range(31);
        it.px    = x;
        it.py    = y;
        it.pz    = z;
        it.raw   = raw;
        it.owner = owner[4:0];
        pending_items.push_back(it);
    endtask

    // Waits until every queued transaction is accepted, every result is back,
    // and the block has dropped busy after the last atom load.
    task automatic drain();
        while (pending_items.size() > 0 || start || weight_expect.size() > 0 || busy)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_count(logic [5:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        count_reg = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Coordinates mostly within eight bohr of the origin so that atoms and
    // points interact; now and then anything the 32-bit field allows.
    function automatic logic [31:0] rand_coord();
        if ($urandom_range(7) == 0) return $urandom;
        return 32'($urandom_range(32'hF_FFFF)) - 32'h8_0000;
    endfunction

    function automatic logic [63:0] rand_raw();
        case ($urandom_range(7))
            0:       return '1;
            1:       return 64'($urandom_range(32'hFFFF));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        int nsel;
        int slot;
        start        = 1'b0;
        i_kind       = bpw_pkg::KIND_LOAD;
        i_atom_slot  = '0;
        i_pos_x      = '0;
        i_pos_y      = '0;
        i_pos_z      = '0;
        i_raw_weight = '0;
        i_owner_atom = '0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        i_rst_n      = 1'b0;
        count_reg    = 6'd1;
        idle_pct     = 18;
        fail_cnt     = 0;
        stall_cyc    = 0;
        foreach (atom_pos[i]) atom_pos[i] = '0;
        foreach (inv_pair[i]) inv_pair[i] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // All 32 slots at one spot: every pair is coincident, so every inverse
        // saturates. Loading them in ascending order also means no later
        // transaction can touch an entry that was never written.
        for (int s = 0; s < bpw_pkg::MAX_ATOMS; s++)
            add_load(s, 32'h0001_8000, 32'hFFFF_0000, 32'h0);
        drain();
        // A count of zero behaves as one atom, which owns the whole weight.
        set_count(6'd0);
        add_point(32'h0, 32'h0, 32'h0, '1, 0);
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 64'h0123_4567_89AB_CDEF, 1);
        drain();
        // With 32 coincident atoms each product underflows to zero.
        set_count(6'd32);
        add_point(32'h0002_0000, 32'h0, 32'h0, '1, 3);
        drain();
        // Counts above the slot range are clipped to the full set.
        set_count(6'd63);
        add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 64'h1, 31);
        drain();

        // A few distinct atoms: a unit spacing, one pair that almost coincides
        // and one atom at each far corner of the coordinate range.
        add_load(0, 32'h0, 32'h0, 32'h0);
        add_load(1, 32'h0001_0000, 32'h0, 32'h0);
        add_load(2, 32'h0000_0800, 32'h0, 32'h0);
        add_load(3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_load(4, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        drain();
        set_count(6'd5);
        add_point(32'h0, 32'h0, 32'h0, '1, 0);
        add_point(32'h0000_8000, 32'h0, 32'h0, '1, 1);
        add_point(32'h0000_0400, 32'h0000_0100, 32'h0, 64'hFFFF_FFFF_0000_0000, 2);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFE, '1, 3);
        add_point(32'h8000_0000, 32'h8000_0001, 32'h8000_0000, 64'h0, 4);
        add_point(32'h0001_0000, 32'h0, 32'h0, '1, 31);
        drain();
        set_count(6'd1);
        add_point(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, '1, 0);
        drain();

        // Random part: three gap profiles, each with several atom counts.
        for (int mode = 0; mode < 3; mode++) begin
            idle_pct = (mode == 0) ? 18 : (mode == 1) ? 83 : 0;
            for (int ph = 0; ph < 5; ph++) begin
                nsel = $urandom_range(9);
                if (nsel == 0)      set_count(6'($urandom_range(9, 12)));
                else if (nsel == 1) set_count(6'd0);
                else                set_count(6'($urandom_range(1, 8)));
                for (int i = 0; i < 34; i++) begin
                    if ($urandom_range(9) < 3) begin
                        // Reloads mostly hit the low slots in use; a high slot
                        // now and then leaves pair entries stale on purpose.
                        slot = ($urandom_range(7) == 0) ? $urandom_range(31)
                                                        : $urandom_range(7);
                        add_load(slot, rand_coord(), rand_coord(), rand_coord());
                    end else begin
                        add_point(rand_coord(), rand_coord(), rand_coord(), rand_raw(),
                                  ($urandom_range(5) == 0) ? $urandom_range(31)
                                                           : $urandom_range(7));
                    end
                end
                drain();
            end
        end

        repeat (50) @(negedge i_clk);
        if (fail_cnt == 0 && weight_expect.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
